// ===== rtl/mhlc_pkg.sv =====
// ============================================================================
// mhlc_pkg
// Shared types and constants of the move-to-front host list cache.
// ============================================================================
package mhlc_pkg;

    localparam int DEPTH_DEF  = 64;
    localparam int LISTS_DEF  = 4;
    localparam int LEN_W      = 7;
    localparam int KEY_W      = 48;
    localparam int ADDR_W_MAX = 12;
    localparam logic [LEN_W-1:0] CURSOR_MAX  = 7'd127;
    localparam logic [LEN_W-1:0] CAPACITY_RST = 7'd50;

    typedef enum logic [2:0] {
        OP_ADD      = 3'd0,
        OP_REMOVE   = 3'd1,
        OP_PROMOTE  = 3'd2,
        OP_DEGRADE  = 3'd3,
        OP_MOVE     = 3'd4,
        OP_GET_NEXT = 3'd5,
        OP_LOOKUP   = 3'd6,
        OP_CLEAR    = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MVSEL,
        ST_FIND,
        ST_SHIFT,
        ST_POST,
        ST_RDWAIT,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        POST_FRONT,
        POST_TAIL,
        POST_REMOVE
    } post_t;

    typedef struct packed {
        op_t         op;
        logic [1:0]  lst;
        logic [31:0] address;
        logic [15:0] port;
    } cmd_t;

    typedef struct packed {
        logic        status;
        logic [5:0]  position;
        logic [31:0] address;
        logic [15:0] port;
        logic        member;
    } res_t;

    // Lists are searched for a move in the order ultrapeer, leaf, working,
    // unidentified, then the higher lists.
    function automatic logic [2:0] mv_order(input logic [2:0] idx);
        logic [2:0] m;
        begin
            case (idx)
                3'd2:    m = 3'd3;
                3'd3:    m = 3'd2;
                default: m = idx;
            endcase
            return m;
        end
    endfunction

endpackage

// ===== rtl/mhlc_ram.sv =====
// ============================================================================
// mhlc_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ============================================================================
module mhlc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/mhlc_ctrl.sv =====
// ============================================================================
// mhlc_ctrl
// Sequencer: searches, shifts and rewrites the entry memory, and keeps the
// per-list lengths and read cursors.
// ============================================================================
module mhlc_ctrl #(
    parameter int DEPTH = mhlc_pkg::DEPTH_DEF,
    parameter int LISTS = mhlc_pkg::LISTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  mhlc_pkg::cmd_t                  cmd,
    input  logic [mhlc_pkg::LEN_W-1:0]      capacity,
    output logic                            idle,
    output logic                            done,
    output mhlc_pkg::res_t                  res,
    input  logic                            res_ack
);

    localparam int AW = $clog2(LISTS * DEPTH);
    localparam int LW = (LISTS > 1) ? $clog2(LISTS) : 1;
    localparam int XW = mhlc_pkg::ADDR_W_MAX;
    localparam int N  = mhlc_pkg::LEN_W;
    localparam logic [8:0] DEPTH9 = 9'(DEPTH);
    localparam logic [3:0] LISTS4 = 4'(LISTS);

    mhlc_pkg::state_t state_reg, state_next;
    mhlc_pkg::op_t    op_reg, op_next;
    mhlc_pkg::post_t  post_reg, post_next;
    logic [1:0]       lst_reg, lst_next;
    logic [mhlc_pkg::KEY_W-1:0] key_reg, key_next;
    logic [2:0]       wl_reg, wl_next;
    logic [3:0]       mv_idx_reg, mv_idx_next;
    logic             mv_add_reg, mv_add_next;
    logic [N-1:0]     scan_reg, scan_next;
    logic             chk_valid_reg, chk_valid_next;
    logic [N-1:0]     chk_idx_reg, chk_idx_next;
    logic [N-1:0]     f_reg, f_next;
    logic [N-1:0]     src_reg, src_next;
    logic [N-1:0]     rem_reg, rem_next;
    logic             up_reg, up_next;
    logic             pend_reg, pend_next;
    logic [N-1:0]     dst_reg, dst_next;
    logic             grow_reg, grow_next;
    mhlc_pkg::res_t   res_reg, res_next;
    logic [N-1:0]     len_reg [LISTS];
    logic [N-1:0]     len_next [LISTS];
    logic [N-1:0]     cur_reg [LISTS];
    logic [N-1:0]     cur_next [LISTS];

    logic             wr_en, rd_en;
    logic [AW-1:0]    wr_addr, rd_addr;
    logic [mhlc_pkg::KEY_W-1:0] wr_data, rd_data;

    logic [LW-1:0]    wl_i;
    logic [N-1:0]     wlen, wcur;
    logic [8:0]       eff9;
    logic [N-1:0]     n_shift;
    logic             fd, miss, add_phase;
    logic [N-1:0]     fidx;
    logic [2:0]       m_list;

    mhlc_ram #(
        .WIDTH (mhlc_pkg::KEY_W),
        .DEPTH (LISTS * DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    function automatic logic [AW-1:0] addr_of(input logic [2:0] l, input logic [N-1:0] i);
        logic [XW-1:0] a;
        begin
            a = XW'(l) * XW'(DEPTH) + XW'(i);
            return a[AW-1:0];
        end
    endfunction

    assign wl_i    = wl_reg[LW-1:0];
    assign wlen    = len_reg[wl_i];
    assign wcur    = cur_reg[wl_i];
    assign eff9    = ({2'b0, capacity} < DEPTH9) ? {2'b0, capacity} : DEPTH9;
    assign n_shift = ({2'b0, wlen} < DEPTH9) ? wlen : N'(DEPTH - 1);
    assign m_list  = mhlc_pkg::mv_order(mv_idx_reg[2:0]);
    assign add_phase = (op_reg == mhlc_pkg::OP_ADD) ||
                       ((op_reg == mhlc_pkg::OP_MOVE) && mv_add_reg);

    assign idle = (state_reg == mhlc_pkg::ST_IDLE);
    assign done = (state_reg == mhlc_pkg::ST_DONE);
    assign res  = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        post_next      = post_reg;
        lst_next       = lst_reg;
        key_next       = key_reg;
        wl_next        = wl_reg;
        mv_idx_next    = mv_idx_reg;
        mv_add_next    = mv_add_reg;
        scan_next      = scan_reg;
        chk_valid_next = chk_valid_reg;
        chk_idx_next   = chk_idx_reg;
        f_next         = f_reg;
        src_next       = src_reg;
        rem_next       = rem_reg;
        up_next        = up_reg;
        pend_next      = pend_reg;
        dst_next       = dst_reg;
        grow_next      = grow_reg;
        res_next       = res_reg;
        len_next       = len_reg;
        cur_next       = cur_reg;
        wr_en          = 1'b0;
        wr_addr        = addr_of(wl_reg, '0);
        wr_data        = key_reg;
        rd_en          = 1'b0;
        rd_addr        = addr_of(wl_reg, scan_reg);
        fd             = 1'b0;
        miss           = 1'b0;
        fidx           = chk_idx_reg;

        unique case (state_reg)
            mhlc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    op_next        = cmd.op;
                    lst_next       = cmd.lst;
                    key_next       = {cmd.port, cmd.address};
                    wl_next        = {1'b0, cmd.lst};
                    mv_idx_next    = '0;
                    mv_add_next    = 1'b0;
                    scan_next      = '0;
                    chk_valid_next = 1'b0;
                    res_next       = '0;
                    if (cmd.op == mhlc_pkg::OP_CLEAR)
                    begin
                        for (int i = 0; i < LISTS; i++)
                        begin
                            len_next[i] = '0;
                            cur_next[i] = '0;
                        end
                        state_next = mhlc_pkg::ST_DONE;
                    end
                    else if ({2'b0, cmd.lst} >= LISTS4)
                    begin
                        res_next.status = 1'b1;
                        state_next      = mhlc_pkg::ST_DONE;
                    end
                    else if (cmd.op == mhlc_pkg::OP_GET_NEXT)
                    begin
                        if (cur_reg[LW'(cmd.lst)] < len_reg[LW'(cmd.lst)])
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = addr_of({1'b0, cmd.lst}, cur_reg[LW'(cmd.lst)]);
                            state_next = mhlc_pkg::ST_RDWAIT;
                        end
                        else
                        begin
                            res_next.status = 1'b1;
                            state_next      = mhlc_pkg::ST_DONE;
                        end
                    end
                    else if (cmd.op == mhlc_pkg::OP_MOVE)
                    begin
                        state_next = mhlc_pkg::ST_MVSEL;
                    end
                    else
                    begin
                        state_next = mhlc_pkg::ST_FIND;
                    end
                end
            end

            mhlc_pkg::ST_MVSEL:
            begin
                scan_next      = '0;
                chk_valid_next = 1'b0;
                if (mv_idx_reg[3])
                begin
                    mv_add_next = 1'b1;
                    wl_next     = {1'b0, lst_reg};
                    state_next  = mhlc_pkg::ST_FIND;
                end
                else if ({1'b0, m_list} < LISTS4)
                begin
                    wl_next    = m_list;
                    state_next = mhlc_pkg::ST_FIND;
                end
                else
                begin
                    mv_idx_next = mv_idx_reg + 4'd1;
                end
            end

            mhlc_pkg::ST_FIND:
            begin
                // One read issued per cycle; the word read last cycle is compared.
                if (chk_valid_reg && (rd_data == key_reg))
                begin
                    fd = 1'b1;
                end
                else if (scan_reg < wlen)
                begin
                    rd_en          = 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_reg;
                    scan_next      = scan_reg + N'(1);
                end
                else
                begin
                    miss = 1'b1;
                end

                if (fd || miss)
                begin
                    f_next    = fidx;
                    pend_next = 1'b0;
                    if (add_phase || (op_reg == mhlc_pkg::OP_PROMOTE))
                    begin
                        up_next   = 1'b1;
                        post_next = mhlc_pkg::POST_FRONT;
                        if (fd)
                        begin
                            rem_next   = fidx;
                            src_next   = fidx - N'(1);
                            grow_next  = 1'b0;
                            state_next = mhlc_pkg::ST_SHIFT;
                            if (op_reg == mhlc_pkg::OP_ADD)
                            begin
                                res_next.position = fidx[5:0];
                            end
                        end
                        else if (op_reg == mhlc_pkg::OP_PROMOTE)
                        begin
                            res_next.status = 1'b1;
                            state_next      = mhlc_pkg::ST_DONE;
                        end
                        else
                        begin
                            rem_next   = n_shift;
                            src_next   = n_shift - N'(1);
                            grow_next  = 1'b1;
                            state_next = mhlc_pkg::ST_SHIFT;
                        end
                    end
                    else if ((op_reg == mhlc_pkg::OP_REMOVE) || (op_reg == mhlc_pkg::OP_MOVE))
                    begin
                        if (fd)
                        begin
                            up_next    = 1'b0;
                            rem_next   = wlen - N'(1) - fidx;
                            src_next   = fidx + N'(1);
                            post_next  = mhlc_pkg::POST_REMOVE;
                            state_next = mhlc_pkg::ST_SHIFT;
                            if (op_reg == mhlc_pkg::OP_REMOVE)
                            begin
                                res_next.position = fidx[5:0];
                            end
                        end
                        else if (op_reg == mhlc_pkg::OP_REMOVE)
                        begin
                            res_next.status = 1'b1;
                            state_next      = mhlc_pkg::ST_DONE;
                        end
                        else
                        begin
                            mv_idx_next = mv_idx_reg + 4'd1;
                            state_next  = mhlc_pkg::ST_MVSEL;
                        end
                    end
                    else if (op_reg == mhlc_pkg::OP_DEGRADE)
                    begin
                        if (fd && ((fidx + N'(1)) < wlen))
                        begin
                            up_next    = 1'b0;
                            rem_next   = wlen - N'(1) - fidx;
                            src_next   = fidx + N'(1);
                            post_next  = mhlc_pkg::POST_TAIL;
                            state_next = mhlc_pkg::ST_SHIFT;
                        end
                        else
                        begin
                            res_next.status = 1'b1;
                            state_next      = mhlc_pkg::ST_DONE;
                        end
                    end
                    else
                    begin
                        res_next.member = fd;
                        res_next.status = ~fd;
                        state_next      = mhlc_pkg::ST_DONE;
                    end
                end
            end

            mhlc_pkg::ST_SHIFT:
            begin
                // Read one entry, write it one place over in the next cycle.
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = addr_of(wl_reg, dst_reg);
                    wr_data = rd_data;
                end
                if (rem_reg != '0)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = addr_of(wl_reg, src_reg);
                    pend_next = 1'b1;
                    dst_next  = up_reg ? (src_reg + N'(1)) : (src_reg - N'(1));
                    src_next  = up_reg ? (src_reg - N'(1)) : (src_reg + N'(1));
                    rem_next  = rem_reg - N'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = mhlc_pkg::ST_POST;
                    end
                end
            end

            mhlc_pkg::ST_POST:
            begin
                unique case (post_reg)
                    mhlc_pkg::POST_FRONT:
                    begin
                        wr_en   = 1'b1;
                        wr_addr = addr_of(wl_reg, '0);
                        if ((wcur != '0) && (wcur < mhlc_pkg::CURSOR_MAX))
                        begin
                            cur_next[wl_i] = wcur + N'(1);
                        end
                        if (grow_reg && (({2'b0, wlen} + 9'd1) <= eff9))
                        begin
                            len_next[wl_i] = wlen + N'(1);
                        end
                        state_next = mhlc_pkg::ST_DONE;
                    end
                    mhlc_pkg::POST_TAIL:
                    begin
                        wr_en   = 1'b1;
                        wr_addr = addr_of(wl_reg, wlen - N'(1));
                        if (wcur > f_reg)
                        begin
                            cur_next[wl_i] = wcur - N'(1);
                        end
                        state_next = mhlc_pkg::ST_DONE;
                    end
                    default:
                    begin
                        len_next[wl_i] = wlen - N'(1);
                        if (wcur > f_reg)
                        begin
                            cur_next[wl_i] = wcur - N'(1);
                        end
                        if (op_reg == mhlc_pkg::OP_MOVE)
                        begin
                            mv_add_next    = 1'b1;
                            wl_next        = {1'b0, lst_reg};
                            scan_next      = '0;
                            chk_valid_next = 1'b0;
                            state_next     = mhlc_pkg::ST_FIND;
                        end
                        else
                        begin
                            state_next = mhlc_pkg::ST_DONE;
                        end
                    end
                endcase
            end

            mhlc_pkg::ST_RDWAIT:
            begin
                res_next.address = rd_data[31:0];
                res_next.port    = rd_data[47:32];
                if (wcur < mhlc_pkg::CURSOR_MAX)
                begin
                    cur_next[wl_i] = wcur + N'(1);
                end
                state_next = mhlc_pkg::ST_DONE;
            end

            mhlc_pkg::ST_DONE:
            begin
                if (res_ack)
                begin
                    state_next = mhlc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = mhlc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mhlc_pkg::ST_IDLE;
            for (int i = 0; i < LISTS; i++)
            begin
                len_reg[i] <= '0;
                cur_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            cur_reg   <= cur_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        post_reg      <= post_next;
        lst_reg       <= lst_next;
        key_reg       <= key_next;
        wl_reg        <= wl_next;
        mv_idx_reg    <= mv_idx_next;
        mv_add_reg    <= mv_add_next;
        scan_reg      <= scan_next;
        chk_valid_reg <= chk_valid_next;
        chk_idx_reg   <= chk_idx_next;
        f_reg         <= f_next;
        src_reg       <= src_next;
        rem_reg       <= rem_next;
        up_reg        <= up_next;
        pend_reg      <= pend_next;
        dst_reg       <= dst_next;
        grow_reg      <= grow_next;
        res_reg       <= res_next;
    end

endmodule

// ===== rtl/mru_host_list_cache_top.sv =====
// ============================================================================
// mru_host_list_cache_top
// Move-to-front host list cache: bounded most-recently-used host lists held
// in one entry memory, with a read cursor per list.
// ============================================================================
//
// Channel   Direction  Signals                         Contents
// s_*       in         s_tvalid s_tready s_tdata s_tuser  one operation word
// m_*       out        m_tvalid m_tready m_tdata m_tuser  one result word
// cfg_*     in         cfg_wr_en cfg_wr_data           list capacity
//
// One operation word is handled at a time. A search checks entries in turn
// (the memory streams one read per cycle), and a shift reads each entry
// moved and writes it one place over. A final step writes the front or
// tail entry, if any, and updates the length or cursor as needed. A move
// may search every list before the add.
// s_tready is high only while the sequencer is idle. The result sits in an
// output register, so a stalled m_tready lets one more operation finish
// before s_tready stays low.
// Reset clears list lengths and cursors and sets the capacity to 50; the
// entry memory is not cleared, since only entries below a list's length
// are ever read.
module mru_host_list_cache_top #(
    parameter int DEPTH = mhlc_pkg::DEPTH_DEF,
    parameter int LISTS = mhlc_pkg::LISTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // host_address, host_port
    input  logic [4:0]  s_tuser,   // operation, list_select
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // position, out_address, out_port, zero fill
    output logic [1:0]  m_tuser,   // status, is_member
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data
);

    logic [mhlc_pkg::LEN_W-1:0] capacity_reg;
    logic                       m_tvalid_reg;
    logic [55:0]                m_tdata_reg;
    logic [1:0]                 m_tuser_reg;
    logic                       idle, done, res_ack, start;
    mhlc_pkg::cmd_t             cmd;
    mhlc_pkg::res_t             res;

    // The sequencer takes a word only when idle.
    assign s_tready = idle;
    assign start    = s_tvalid && idle;

    assign cmd.op      = mhlc_pkg::op_t'(s_tuser[2:0]);
    assign cmd.lst     = s_tuser[4:3];
    assign cmd.address = s_tdata[31:0];
    assign cmd.port    = s_tdata[47:32];

    // A finished result moves into the output register when that is free.
    assign res_ack = done && (!m_tvalid_reg || m_tready);

    mhlc_ctrl #(
        .DEPTH (DEPTH),
        .LISTS (LISTS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd      (cmd),
        .capacity (capacity_reg),
        .idle     (idle),
        .done     (done),
        .res      (res),
        .res_ack  (res_ack)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= mhlc_pkg::CAPACITY_RST;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
            if (res_ack)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ack)
        begin
            m_tdata_reg <= {2'b00, res.port, res.address, res.position};
            m_tuser_reg <= {res.member, res.status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
